@@ sv/assert_macros.svh @@
// Assertion macros for the RTL of the top-k score selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg)

`endif

`endif

@@ sv/tks_pkg.sv @@
// Package with the fixed widths and codes of the top-k score selector.
`timescale 1ns / 1ps

package tks_pkg;

    localparam int SCORE_W = 16;
    localparam int KEEP_W  = 5;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_DRAIN  = 1'b1
    } opcode_t;

endpackage

@@ sv/top_k_score_selector_top.sv @@
// Top level of the top-k score selector: sorted register store with streaming I/O.
`timescale 1ns / 1ps
//
// The block keeps the keep_count best-scoring candidates it has seen, held in a
// register store sorted best first. Items arrive on the slave stream: tuser
// carries the opcode (insert or drain) and tdata carries a signed Q1.15 score
// and a tag. An insert is taken in every cycle without a drain in progress and
// produces no result: it is compared in parallel against every held entry and
// shifted into place in the same cycle, evicting the last (worst, most recently
// kept) entry when full. A drain transfer stops further input and emits the held
// entries on the master stream, best first, one per cycle while the receiver
// accepts, with tlast on the final one; the store is cleared as it empties. A
// drain of an empty store emits one result with tuser set, tlast set and zero
// data. The drain transfer first sets the drain state, and each result then
// passes through the single output register. s_tready stays low until the last
// result is loaded. Inserts sustain one transfer per cycle outside a drain,
// also while the last drain result still waits in the output register.
// When the receiver stalls, the output register holds its result and the
// store stops shifting until the transfer completes.
// Reset clears the held count, the drain state and the output valid, and sets
// keep_count to 16; the stored scores and tags are not reset.
//
`include "assert_macros.svh"

module top_k_score_selector_top
    import tks_pkg::*;
#(
    parameter int MAX_KEEP = 16,
    parameter int TAG_BITS = 16
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration write of keep_count.
    input  logic                                   keep_count_we,
    input  logic [KEEP_W-1:0]                      keep_count_wdata,
    // Input stream. tdata fields from bit 0 up: score, tag, zero padding.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SCORE_W+TAG_BITS+7)/8)*8-1:0]  s_tdata,
    // tuser fields from bit 0 up: opcode.
    input  logic [0:0]                             s_tuser,
    // Result stream. tdata fields from bit 0 up: out_score, out_tag, zero padding.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((SCORE_W+TAG_BITS+7)/8)*8-1:0]  m_tdata,
    output logic                                   m_tlast,
    // tuser fields from bit 0 up: empty_res.
    output logic [0:0]                             m_tuser
);

    localparam int DATA_W = ((SCORE_W + TAG_BITS + 7) / 8) * 8;
    localparam int CW     = $clog2(MAX_KEEP + 1);
    localparam int EW     = (CW > KEEP_W) ? CW : KEEP_W;

    // Store and control registers.
    logic signed [SCORE_W-1:0]  score_reg [MAX_KEEP];
    logic signed [SCORE_W-1:0]  score_next [MAX_KEEP];
    logic [TAG_BITS-1:0]        tag_reg [MAX_KEEP];
    logic [TAG_BITS-1:0]        tag_next [MAX_KEEP];
    logic [CW-1:0]              count_reg, count_next;
    logic [KEEP_W-1:0]          keep_reg;
    logic                       draining_reg, draining_next;

    // Output register.
    logic                       out_valid_reg, out_valid_next;
    logic signed [SCORE_W-1:0]  out_score_reg, out_score_next;
    logic [TAG_BITS-1:0]        out_tag_reg, out_tag_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_empty_reg, out_empty_next;

    logic signed [SCORE_W-1:0]  in_score;
    logic [TAG_BITS-1:0]        in_tag;
    opcode_t                    in_op;
    logic                       in_xfer;

    logic [EW-1:0]              keep_wide;
    logic [EW-1:0]              keep_eff;
    logic                       not_full;
    logic [MAX_KEEP-1:0]        ge;
    logic [MAX_KEEP-1:0]        below_count;
    logic                       beats_one;
    logic [CW-1:0]              insert_m;
    logic                       do_insert;
    logic                       drain_step;
    logic                       sorted_ok;

    assign in_score = s_tdata[SCORE_W-1:0];
    assign in_tag   = s_tdata[SCORE_W +: TAG_BITS];
    assign in_op    = opcode_t'(s_tuser[0]);

    // Input is held off while a drain walks the store out.
    assign s_tready = !draining_reg;
    assign in_xfer  = s_tvalid && s_tready;

    // A keep count of zero acts as one, and one above the depth as the depth.
    always_comb
    begin
        keep_wide = EW'(keep_reg);
        if (keep_wide == '0)
        begin
            keep_eff = EW'(1);
        end
        else if (keep_wide > EW'(MAX_KEEP))
        begin
            keep_eff = EW'(MAX_KEEP);
        end
        else
        begin
            keep_eff = keep_wide;
        end
    end

    assign not_full = EW'(count_reg) < keep_eff;

    // Parallel compare against the held entries. Because the store is sorted,
    // ge is a run of ones from bit 0 and its length is the insertion point.
    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            below_count[i] = CW'(i) < count_reg;
            ge[i]          = below_count[i] && (score_reg[i] >= in_score);
        end
    end

    // When full, the new score must strictly beat the last held entry.
    assign beats_one = |(below_count & ~ge);
    assign insert_m  = not_full ? count_reg : count_reg - CW'(1);
    assign do_insert = in_xfer && (in_op == OP_INSERT) && (not_full || beats_one);

    assign drain_step = draining_reg && (!out_valid_reg || m_tready);

    // Store update: shift-insert on an insert, shift toward the head on a drain.
    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            score_next[i] = score_reg[i];
            tag_next[i]   = tag_reg[i];
            if (do_insert)
            begin
                if (!ge[i])
                begin
                    if (i == 0)
                    begin
                        score_next[i] = in_score;
                        tag_next[i]   = in_tag;
                    end
                    else if (ge[i-1])
                    begin
                        score_next[i] = in_score;
                        tag_next[i]   = in_tag;
                    end
                    else if (CW'(i) <= insert_m)
                    begin
                        score_next[i] = score_reg[i-1];
                        tag_next[i]   = tag_reg[i-1];
                    end
                end
            end
            else if (drain_step && (i < MAX_KEEP - 1))
            begin
                score_next[i] = score_reg[i+1];
                tag_next[i]   = tag_reg[i+1];
            end
        end
    end

    // Held count, drain state and output register.
    always_comb
    begin
        count_next     = count_reg;
        draining_next  = draining_reg;
        out_valid_next = out_valid_reg;
        out_score_next = out_score_reg;
        out_tag_next   = out_tag_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (do_insert && not_full)
        begin
            count_next = count_reg + CW'(1);
        end

        if (in_xfer && (in_op == OP_DRAIN))
        begin
            draining_next = 1'b1;
        end

        if (drain_step)
        begin
            out_valid_next = 1'b1;
            if (count_reg == '0)
            begin
                out_score_next = '0;
                out_tag_next   = '0;
                out_last_next  = 1'b1;
                out_empty_next = 1'b1;
                draining_next  = 1'b0;
            end
            else
            begin
                out_score_next = score_reg[0];
                out_tag_next   = tag_reg[0];
                out_last_next  = (count_reg == CW'(1));
                out_empty_next = 1'b0;
                count_next     = count_reg - CW'(1);
                if (count_reg == CW'(1))
                begin
                    draining_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            keep_reg      <= KEEP_RESET;
            draining_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            draining_reg  <= draining_next;
            out_valid_reg <= out_valid_next;
            if (keep_count_we)
            begin
                keep_reg <= keep_count_wdata;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            score_reg[i] <= score_next[i];
            tag_reg[i]   <= tag_next[i];
        end
        out_score_reg <= out_score_next;
        out_tag_reg   <= out_tag_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = DATA_W'({out_tag_reg, out_score_reg});
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_empty_reg;

    // Held entries stay in descending score order.
    always_comb
    begin
        sorted_ok = 1'b1;
        for (int i = 0; i < MAX_KEEP - 1; i++)
        begin
            if ((CW'(i + 1) < count_reg) && (score_reg[i] < score_reg[i+1]))
            begin
                sorted_ok = 1'b0;
            end
        end
    end

    `ASSERT_ALWAYS(a_count_in_range, clk, rst_n, count_reg <= CW'(MAX_KEEP),
        "held count exceeds store depth")
    `ASSERT_ALWAYS(a_store_sorted, clk, rst_n, sorted_ok,
        "store is not sorted best first")
    `ASSERT_IMPLIES(a_more_pending, clk, rst_n, m_tvalid && !m_tlast, draining_reg,
        "drain result without last while drain is finished")
    `ASSERT_IMPLIES(a_empty_is_last, clk, rst_n, m_tvalid && m_tuser[0],
        m_tlast && (m_tdata == '0), "empty drain result is not last or not zero")

endmodule

@@ tb/tb_top_k_score_selector_top.sv @@
// Self-checking testbench for the top-k score selector with its own model of the kept set.
`timescale 1ns / 1ps
//
// The testbench drives insert and drain transfers into the selector and checks
// every drain result against a model of the kept set. The model is updated when
// an input transfer is accepted.
//
// The sender offers items in bursts of random length with random gaps between
// them. The receiver stalls on its own pattern, and once it holds off for a long
// stretch so that a drain backs up into the input stream.
//
// keep_count is only written while the selector is idle. It takes the reset
// value, out-of-range values at both ends, and values below the number of
// entries already held.
//
module tb_top_k_score_selector_top
    import tks_pkg::*;
();

    localparam int TAG_W        = 16;
    localparam int STORE_DEPTH  = 16;
    localparam int DATA_W       = ((SCORE_W + TAG_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 360;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;

    // One expected drain result, with the same fields that the result stream carries.
    typedef struct {
        logic signed [SCORE_W-1:0] score;
        logic [TAG_W-1:0]          tag;
        logic                      last;
        logic                      empty;
    } drain_entry_t;

    // The tracker holds its own copy of the kept set, sorted best first. It queues
    // the results that each accepted drain must produce.
    class best_k_tracker;
        logic signed [SCORE_W-1:0] kept_score [STORE_DEPTH];
        logic [TAG_W-1:0]          kept_tag [STORE_DEPTH];
        int                        held;
        logic [KEEP_W-1:0]         keep_reg;
        drain_entry_t              due_results [$];
        int                        fail_count;

        function new();
            held       = 0;
            keep_reg   = KEEP_RESET;
            fail_count = 0;
        endfunction

        function void set_keep(logic [KEEP_W-1:0] value);
            keep_reg = value;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // This puts an entry into slots [0, n] and shifts the worse entries down
        // by one slot. A new entry goes after every held entry of equal score.
        function void place_sorted(int n, logic signed [SCORE_W-1:0] score,
                                   logic [TAG_W-1:0] tag);
            int pos;
            pos = 0;
            while (pos < n && kept_score[pos] >= score)
                pos++;
            for (int i = n; i > pos; i--)
            begin
                kept_score[i] = kept_score[i-1];
                kept_tag[i]   = kept_tag[i-1];
            end
            kept_score[pos] = score;
            kept_tag[pos]   = tag;
        endfunction

        function void take_item(opcode_t op, logic signed [SCORE_W-1:0] score,
                                logic [TAG_W-1:0] tag);
            int           limit;
            drain_entry_t entry;
            // A keep count of zero acts as one. Values above the store depth act as
            // the full depth.
            limit = (keep_reg == 0) ? 1 : ((keep_reg > STORE_DEPTH) ? STORE_DEPTH : keep_reg);
            if (op == OP_INSERT)
            begin
                if (held < limit)
                begin
                    place_sorted(held, score, tag);
                    held++;
                end
                else if (held > 0 && score > kept_score[held-1])
                begin
                    // The candidate evicts the last entry. That entry is the most
                    // recently kept one among those with the minimum score.
                    place_sorted(held - 1, score, tag);
                end
            end
            else if (held == 0)
            begin
                entry.score = '0;
                entry.tag   = '0;
                entry.last  = 1'b1;
                entry.empty = 1'b1;
                due_results = {due_results, entry};
            end
            else
            begin
                for (int i = 0; i < held; i++)
                begin
                    entry.score = kept_score[i];
                    entry.tag   = kept_tag[i];
                    entry.last  = (i == held - 1);
                    entry.empty = 1'b0;
                    due_results = {due_results, entry};
                end
                held = 0;
            end
        endfunction

        function void match_drain_result(logic signed [SCORE_W-1:0] score,
                                         logic [TAG_W-1:0] tag, logic last, logic empty);
            drain_entry_t due;
            if (due_results.size() == 0)
            begin
                $error("unexpected result: out_score %0d out_tag %0d", score, tag);
                fail_count++;
                return;
            end
            due = due_results.pop_front();
            if (score !== due.score)
            begin
                $error("out_score expected %0d got %0d", due.score, score);
                fail_count++;
            end
            if (tag !== due.tag)
            begin
                $error("out_tag expected %0d got %0d", due.tag, tag);
                fail_count++;
            end
            if (last !== due.last)
            begin
                $error("last expected %0d got %0d", due.last, last);
                fail_count++;
            end
            if (empty !== due.empty)
            begin
                $error("empty_res expected %0d got %0d", due.empty, empty);
                fail_count++;
            end
        endfunction
    endclass

    logic              clk              = 1'b0;
    logic              rst_n            = 1'b0;
    logic              keep_count_we    = 1'b0;
    logic [KEEP_W-1:0] keep_count_wdata = '0;
    logic              s_tvalid         = 1'b0;
    logic              s_tready;
    // tdata fields from bit 0 up: score, tag.
    logic [DATA_W-1:0] s_tdata          = '0;
    // tuser fields from bit 0 up: opcode.
    logic [0:0]        s_tuser          = 1'b0;
    logic              m_tvalid;
    logic              m_tready         = 1'b0;
    // tdata fields from bit 0 up: out_score, out_tag.
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    // tuser fields from bit 0 up: empty_res.
    logic [0:0]        m_tuser;

    best_k_tracker tracker = new();
    int            run_left   = 0;
    int            items_sent = 0;
    bit            hold_req   = 1'b0;

    always #2 clk = ~clk;

    top_k_score_selector_top #(
        .MAX_KEEP (STORE_DEPTH),
        .TAG_BITS (TAG_W)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .keep_count_we    (keep_count_we),
        .keep_count_wdata (keep_count_wdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast),
        .m_tuser          (m_tuser)
    );

    // Outputs are sampled at the rising edge, so the values seen are the ones the
    // selector held before the edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.match_drain_result(m_tdata[SCORE_W-1:0], m_tdata[SCORE_W +: TAG_W],
                                       m_tlast, m_tuser[0]);
    end

    // The receiver cycles through several stall patterns. Always ready is one of
    // them, so there are stretches with no stalls. When the main sequence asks
    // for it, the receiver holds off once for a long stretch that it counts itself.
    initial
    begin
        int cyc;
        bit hold_done;
        cyc       = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                cyc++;
                case ((cyc / 97) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) != 0);
                    2:       m_tready <= (cyc % 4) != 0;
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // The watchdog counts cycles in which neither stream completes a transfer.
    // The longest legal quiet stretch is the long receiver hold.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    // This offers one item and returns at the edge where it is accepted. A new
    // burst may begin with a random gap. Inside a burst, tvalid stays high from
    // one item to the next.
    task automatic offer_item(input opcode_t op, input logic [SCORE_W-1:0] score,
                              input logic [TAG_W-1:0] tag);
        int gap;
        if (run_left == 0)
        begin
            run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        run_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {tag, score};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.take_item(op, score, tag);
        items_sent++;
    endtask

    // This drops tvalid and waits until every drain result has arrived. It then
    // lets a trailing insert finish before it returns.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_keep(input logic [KEEP_W-1:0] value);
        settle();
        keep_count_we    <= 1'b1;
        keep_count_wdata <= value;
        @(posedge clk);
        keep_count_we    <= 1'b0;
        tracker.set_keep(value);
    endtask

    // Scores are drawn from a narrow band around zero so that ties are common,
    // from the extremes, or from the full range.
    function automatic logic [SCORE_W-1:0] pick_score();
        int v;
        case ($urandom_range(0, 3))
            0:       v = $urandom_range(0, 8) - 4;
            1:       v = ($urandom_range(0, 1) ? 32767 : -32768) + $urandom_range(0, 1)
                         * ($urandom_range(0, 1) ? -1 : 1);
            default: v = $urandom;
        endcase
        return v[SCORE_W-1:0];
    endfunction

    task automatic insert_run(input int count);
        repeat (count) offer_item(OP_INSERT, pick_score(), TAG_W'($urandom));
    endtask

    task automatic drain_store();
        offer_item(OP_DRAIN, SCORE_W'($urandom), TAG_W'($urandom));
    endtask

    initial
    begin
        logic [KEEP_W-1:0] keep_plan [6];
        logic [KEEP_W-1:0] keep_value;
        int                phase;

        keep_plan = '{5'd0, 5'd31, 5'd17, 5'd1, 5'd16, 5'd5};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with keep_count at its reset value. The first drain
        // finds an empty store. Then the extreme scores and tags go in, along
        // with two equal scores that must come back in the order they were kept.
        drain_store();
        offer_item(OP_INSERT, 16'h7FFF, 16'hFFFF);
        offer_item(OP_INSERT, 16'h8000, 16'h0000);
        offer_item(OP_INSERT, 16'h0000, 16'h1234);
        offer_item(OP_INSERT, 16'h0000, 16'h5678);
        offer_item(OP_INSERT, 16'hFFFF, 16'hAAAA);
        offer_item(OP_INSERT, 16'h0001, 16'h5555);
        drain_store();
        drain_store();

        // This checks a full store of two. An equal score is rejected, a better
        // score evicts the later of the two equal entries, and the minimum score
        // is rejected.
        write_keep(5'd2);
        offer_item(OP_INSERT, 16'd100, 16'h000A);
        offer_item(OP_INSERT, 16'd100, 16'h000B);
        offer_item(OP_INSERT, 16'd100, 16'h000C);
        offer_item(OP_INSERT, 16'd200, 16'h000D);
        offer_item(OP_INSERT, 16'h8000, 16'h000E);
        drain_store();

        // Here keep_count is lowered below the number held. No entry is dropped,
        // and every insert is then treated as one into a full store.
        write_keep(5'd16);
        for (int i = 1; i <= 5; i++)
            offer_item(OP_INSERT, 16'(i * 10), 16'(i));
        write_keep(5'd1);
        offer_item(OP_INSERT, 16'd5, 16'h0101);
        offer_item(OP_INSERT, 16'd15, 16'h0202);
        offer_item(OP_INSERT, 16'd15, 16'h0303);
        drain_store();

        // Random part. Each phase sets keep_count, runs rounds of inserts that
        // each end in a drain, and sometimes leaves entries held for the next
        // keep_count change.
        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            keep_value = (phase < 6) ? keep_plan[phase] : KEEP_W'($urandom_range(0, 31));
            write_keep(keep_value);
            if (phase == 2)
            begin
                // The long receiver hold. The drain cannot empty into the output,
                // so the input stream stalls while the sender keeps offering.
                hold_req = 1'b1;
                insert_run(20);
                drain_store();
                insert_run(10);
                drain_store();
            end
            repeat ($urandom_range(1, 4))
            begin
                insert_run(($urandom_range(0, 4) == 0) ? $urandom_range(30, 50)
                                                       : $urandom_range(0, 24));
                drain_store();
                if ($urandom_range(0, 4) == 0)
                    drain_store();
            end
            if ($urandom_range(0, 1) != 0)
                insert_run($urandom_range(0, 20));
            phase++;
        end
        drain_store();

        settle();
        repeat (16) @(posedge clk);
        if (tracker.fail_count == 0 && tracker.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/tks_pkg.sv
sv/top_k_score_selector_top.sv
tb/tb_top_k_score_selector_top.sv
